// ===== rtl/psd_pkg.sv =====
// Shared types and defaults for the point to segment distance pipeline.
// No dependencies; every other file in rtl imports this package.
package psd_pkg;

	localparam int COORD_BITS_DEF = 24;

	typedef enum logic [1:0] {
		CASE_START = 2'd0,
		CASE_END   = 2'd1,
		CASE_FOOT  = 2'd2
	} kind_t;

endpackage

// ===== rtl/psd_dot.sv =====
// Difference, product and dot product stages (three register stages).
// Depends on psd_pkg for parameter defaults.
module psd_dot #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] q_pt [3],
	input  logic signed [COORD_BITS-1:0] s_pt [3],
	input  logic signed [COORD_BITS-1:0] e_pt [3],
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [2*COORD_BITS+3:0] c1,
	output logic [2*COORD_BITS+1:0]      c2,
	output logic [2*COORD_BITS+1:0]      ww,
	output logic [2*COORD_BITS+1:0]      uu
);
	import psd_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int MW = PW;
	localparam int SW = PW + 2;

	logic [2:0] v_q;
	logic       load0, load1, load2;

	logic signed [DW-1:0] v_s1 [3];
	logic signed [DW-1:0] w_s1 [3];
	logic signed [DW-1:0] u_s1 [3];
	logic signed [PW-1:0] pwv_s2 [3];
	logic signed [PW-1:0] pvv_s2 [3];
	logic signed [PW-1:0] pww_s2 [3];
	logic signed [PW-1:0] puu_s2 [3];
	logic signed [SW-1:0] c1_s3;
	logic [MW-1:0]        c2_s3, ww_s3, uu_s3;

	assign load2    = !v_q[2] || out_ready;
	assign load1    = !v_q[1] || load2;
	assign load0    = !v_q[0] || load1;
	assign in_ready = load0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (load0) v_q[0] <= in_valid;
			if (load1) v_q[1] <= v_q[0];
			if (load2) v_q[2] <= v_q[1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (load0) begin
				v_s1[i] <= DW'(e_pt[i]) - DW'(s_pt[i]);
				w_s1[i] <= DW'(q_pt[i]) - DW'(s_pt[i]);
				u_s1[i] <= DW'(q_pt[i]) - DW'(e_pt[i]);
			end
			if (load1) begin
				pwv_s2[i] <= PW'(w_s1[i]) * PW'(v_s1[i]);
				pvv_s2[i] <= PW'(v_s1[i]) * PW'(v_s1[i]);
				pww_s2[i] <= PW'(w_s1[i]) * PW'(w_s1[i]);
				puu_s2[i] <= PW'(u_s1[i]) * PW'(u_s1[i]);
			end
		end
		if (load2) begin
			c1_s3 <= SW'(pwv_s2[0]) + SW'(pwv_s2[1]) + SW'(pwv_s2[2]);
			c2_s3 <= MW'(SW'(pvv_s2[0]) + SW'(pvv_s2[1]) + SW'(pvv_s2[2]));
			ww_s3 <= MW'(SW'(pww_s2[0]) + SW'(pww_s2[1]) + SW'(pww_s2[2]));
			uu_s3 <= MW'(SW'(puu_s2[0]) + SW'(puu_s2[1]) + SW'(puu_s2[2]));
		end
	end

	assign out_valid = v_q[2];
	assign c1        = c1_s3;
	assign c2        = c2_s3;
	assign ww        = ww_s3;
	assign uu        = uu_s3;
endmodule

// ===== rtl/psd_div.sv =====
// Case selection and a radix-2 quotient pipeline for ceil(c1*c1/c2),
// ending in the squared distance. Depends on psd_pkg for kind_t.
module psd_div #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [2*COORD_BITS+3:0] c1,
	input  logic [2*COORD_BITS+1:0]        c2,
	input  logic [2*COORD_BITS+1:0]        ww,
	input  logic [2*COORD_BITS+1:0]        uu,
	output logic                           out_valid,
	input  logic                           out_ready,
	output psd_pkg::kind_t                 kind,
	output logic [2*COORD_BITS+1:0]        dsq
);
	import psd_pkg::*;

	localparam int MW = 2 * COORD_BITS + 2;
	localparam int RW = MW + 2;
	localparam int N  = MW + 2;

	logic [N-1:0] v_q;
	logic [N:0]   load;

	kind_t         kind_s [N];
	logic [MW-1:0] a_s    [N];
	logic [MW-1:0] d_s    [N];
	logic [MW-1:0] base_s [N];
	logic [MW-1:0] q_s    [N];
	logic [RW-1:0] rem_s  [N];

	logic [MW-1:0] c1m;
	kind_t         kind_c;

	assign load[N]  = out_ready;
	assign in_ready = load[0];

	always_comb begin
		c1m = MW'(c1);
		if (c1 <= 0) begin
			kind_c = CASE_START;
		end else if (c2 <= c1m) begin
			kind_c = CASE_END;
		end else begin
			kind_c = CASE_FOOT;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		assign load[k] = !v_q[k] || load[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (load[k]) begin
				v_q[k] <= (k == 0) ? in_valid : v_q[(k == 0) ? 0 : k-1];
			end
		end

		if (k == 0) begin : g_entry
			always_ff @(posedge clk) begin
				if (load[k]) begin
					kind_s[k] <= kind_c;
					a_s[k]    <= (kind_c == CASE_FOOT) ? c1m : '0;
					d_s[k]    <= c2;
					base_s[k] <= (kind_c == CASE_END) ? uu : ww;
					q_s[k]    <= '0;
					rem_s[k]  <= '0;
				end
			end
		end else if (k <= MW) begin : g_step
			logic [RW-1:0] r1, r2, r3;
			logic [1:0]    inc;
			always_comb begin
				r1  = {rem_s[k-1][RW-2:0], 1'b0}
					+ (a_s[k-1][MW-k] ? RW'(a_s[k-1]) : '0);
				inc = '0;
				r2  = r1;
				if (r1 >= RW'(d_s[k-1])) begin
					r2  = r1 - RW'(d_s[k-1]);
					inc = 2'd1;
				end
				r3 = r2;
				if (r2 >= RW'(d_s[k-1])) begin
					r3  = r2 - RW'(d_s[k-1]);
					inc = inc + 2'd1;
				end
			end
			always_ff @(posedge clk) begin
				if (load[k]) begin
					kind_s[k] <= kind_s[k-1];
					a_s[k]    <= a_s[k-1];
					d_s[k]    <= d_s[k-1];
					base_s[k] <= base_s[k-1];
					q_s[k]    <= {q_s[k-1][MW-2:0], 1'b0} + MW'(inc);
					rem_s[k]  <= r3;
				end
			end
		end else begin : g_final
			always_ff @(posedge clk) begin
				if (load[k]) begin
					kind_s[k] <= kind_s[k-1];
					a_s[k]    <= a_s[k-1];
					d_s[k]    <= d_s[k-1];
					q_s[k]    <= q_s[k-1];
					rem_s[k]  <= rem_s[k-1];
					if (kind_s[k-1] == CASE_FOOT) begin
						base_s[k] <= base_s[k-1] - q_s[k-1]
							- MW'(rem_s[k-1] != '0);
					end else begin
						base_s[k] <= base_s[k-1];
					end
				end
			end
		end
	end

	assign out_valid = v_q[N-1];
	assign kind      = kind_s[N-1];
	assign dsq       = base_s[N-1];
endmodule

// ===== rtl/psd_sqrt.sv =====
// Digit-by-digit integer square root pipeline, one root bit a stage.
// Depends on psd_pkg for kind_t.
module psd_sqrt #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  psd_pkg::kind_t          kind_in,
	input  logic [2*COORD_BITS+1:0] dsq,
	output logic                    out_valid,
	input  logic                    out_ready,
	output psd_pkg::kind_t          kind_out,
	output logic [COORD_BITS:0]     root
);
	import psd_pkg::*;

	localparam int RW = COORD_BITS + 1;
	localparam int MW = 2 * RW;
	localparam int N  = RW;

	logic [N-1:0] v_q;
	logic [N:0]   load;

	kind_t         kind_s [N];
	logic [MW-1:0] rem_s  [N];
	logic [RW-1:0] root_s [N];

	assign load[N]  = out_ready;
	assign in_ready = load[0];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int B = RW - 1 - k;
		logic [MW-1:0] rem_p, t;
		logic [RW-1:0] root_p;
		kind_t         kind_p;
		logic          v_p;

		if (k == 0) begin : g_first
			assign rem_p  = dsq;
			assign root_p = '0;
			assign kind_p = kind_in;
			assign v_p    = in_valid;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign kind_p = kind_s[k-1];
			assign v_p    = v_q[k-1];
		end

		assign load[k] = !v_q[k] || load[k+1];
		assign t = (MW'(root_p) << (B + 1)) | (MW'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (load[k]) begin
				v_q[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (load[k]) begin
				kind_s[k] <= kind_p;
				if (rem_p >= t) begin
					rem_s[k]  <= rem_p - t;
					root_s[k] <= root_p | (RW'(1) << B);
				end else begin
					rem_s[k]  <= rem_p;
					root_s[k] <= root_p;
				end
			end
		end
	end

	assign out_valid = v_q[N-1];
	assign kind_out  = kind_s[N-1];
	assign root      = root_s[N-1];
endmodule

// ===== rtl/point_segment_distance_3d.sv =====
// Top level: distance from a point to a 3D segment, fully pipelined.
// Depends on psd_pkg, psd_dot, psd_div and psd_sqrt.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  request | req_valid / req_ready | query_*, start_*, end_* (signed)
//  result  | rsp_valid / rsp_ready | distance, nearest_case
//
// One item per cycle while rsp_ready holds; each item passes through the
// dot product, quotient and root bit pipelines in that order.
// Each stage holds its own valid bit and loads when it is empty or its
// successor loads, so bubbles close up and a stalled result does not
// block new items while empty stages remain. Reset clears valid bits only.
module point_segment_distance_3d #(
	parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic signed [COORD_BITS-1:0] query_x,
	input  logic signed [COORD_BITS-1:0] query_y,
	input  logic signed [COORD_BITS-1:0] query_z,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] start_z,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] end_z,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [COORD_BITS:0]          distance,
	output logic [1:0]                   nearest_case
);
	import psd_pkg::*;

	localparam int MW = 2 * COORD_BITS + 2;

	logic signed [COORD_BITS-1:0] q_pt [3];
	logic signed [COORD_BITS-1:0] s_pt [3];
	logic signed [COORD_BITS-1:0] e_pt [3];

	logic               dot_valid, dot_ready, div_valid, div_ready;
	logic signed [MW+1:0] c1;
	logic [MW-1:0]      c2, ww, uu, dsq;
	kind_t              kind_div, kind_out;

	assign q_pt[0] = query_x;
	assign q_pt[1] = query_y;
	assign q_pt[2] = query_z;
	assign s_pt[0] = start_x;
	assign s_pt[1] = start_y;
	assign s_pt[2] = start_z;
	assign e_pt[0] = end_x;
	assign e_pt[1] = end_y;
	assign e_pt[2] = end_z;

	psd_dot #(.COORD_BITS(COORD_BITS)) u_dot (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_valid), .in_ready(req_ready),
		.q_pt(q_pt), .s_pt(s_pt), .e_pt(e_pt),
		.out_valid(dot_valid), .out_ready(dot_ready),
		.c1(c1), .c2(c2), .ww(ww), .uu(uu)
	);

	psd_div #(.COORD_BITS(COORD_BITS)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(dot_valid), .in_ready(dot_ready),
		.c1(c1), .c2(c2), .ww(ww), .uu(uu),
		.out_valid(div_valid), .out_ready(div_ready),
		.kind(kind_div), .dsq(dsq)
	);

	psd_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(div_valid), .in_ready(div_ready),
		.kind_in(kind_div), .dsq(dsq),
		.out_valid(rsp_valid), .out_ready(rsp_ready),
		.kind_out(kind_out), .root(distance)
	);

	assign nearest_case = kind_out;
endmodule

// ===== bench/tb_point_segment_distance_3d.sv =====
// Testbench for point_segment_distance_3d: random and directed segment queries
// checked against an exact fixed-point distance model. Depends on psd_pkg.
module tb_point_segment_distance_3d;
	timeunit 1ns;
	timeprecision 1ps;
	import psd_pkg::*;

	localparam int CB = 24;
	localparam int DB = CB + 1;
	localparam int N_ITEMS = 800;
	localparam int LIMIT = 400000;

	typedef logic signed [CB-1:0] crd_t;
	typedef struct {
		logic [DB-1:0] dist_val;
		kind_t         kind;
	} dist_res_t;

	class dist_scoreboard;
		dist_res_t pending[$];
		int errors;
		int checked;
		int kind_seen[3];

		// floor of sqrt(num/den), exact with wide integers
		function logic [DB-1:0] root_floor(logic [255:0] num, logic [255:0] den);
			logic [DB-1:0] r;
			logic [DB-1:0] cand;
			logic [255:0] sq;
			r = '0;
			for (int b = DB - 1; b >= 0; b--) begin
				cand = r | (DB'(1) << b);
				sq = 256'(cand) * 256'(cand) * den;
				if (sq <= num)
					r = cand;
			end
			return r;
		endfunction

		function void note_query(crd_t q[3], crd_t s[3], crd_t e[3]);
			logic signed [127:0] c1, c2, ww, uu, v, w, u;
			logic [255:0] num, den;
			dist_res_t r;
			c1 = '0; c2 = '0; ww = '0; uu = '0;
			for (int i = 0; i < 3; i++) begin
				v = 128'(e[i]) - 128'(s[i]);
				w = 128'(q[i]) - 128'(s[i]);
				u = 128'(q[i]) - 128'(e[i]);
				c1 += w * v;
				c2 += v * v;
				ww += w * w;
				uu += u * u;
			end
			if (c1 <= 0) begin
				r.kind = CASE_START;
				num = 256'(ww);
				den = 256'd1;
			end else if (c2 <= c1) begin
				r.kind = CASE_END;
				num = 256'(uu);
				den = 256'd1;
			end else begin
				r.kind = CASE_FOOT;
				num = 256'(ww) * 256'(c2) - 256'(c1) * 256'(c1);
				den = 256'(c2);
			end
			r.dist_val = root_floor(num, den);
			pending.push_back(r);
		endfunction

		function void check_result(logic [DB-1:0] dist_act, logic [1:0] kind);
			dist_res_t x;
			if (pending.size() == 0) begin
				$error("unexpected item: distance %0d nearest_case %0d", dist_act, kind);
				errors++;
				return;
			end
			x = pending.pop_front();
			checked++;
			kind_seen[x.kind]++;
			if (dist_act !== x.dist_val) begin
				$error("distance: expected %0d actual %0d", x.dist_val, dist_act);
				errors++;
			end
			if (kind !== x.kind) begin
				$error("nearest_case: expected %0d actual %0d", x.kind, kind);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
	crd_t query_x = 0, query_y = 0, query_z = 0;
	crd_t start_x = 0, start_y = 0, start_z = 0;
	crd_t end_x = 0, end_y = 0, end_z = 0;
	logic [DB-1:0] distance;
	logic [1:0] nearest_case;
	dist_scoreboard sb = new();
	int cycles = 0;
	bit stim_done = 0;

	point_segment_distance_3d u_top (.*);

	initial forever #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
		if (rsp_valid && rsp_ready)
			sb.check_result(distance, nearest_case);
	end

	// receiver stall pattern: randomly chosen modes of free flow and random stalls
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 60)) begin
				@(negedge clk);
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ready <= ($urandom_range(0, 1) == 1);
				endcase
			end
		end
	end

	task automatic send_query(crd_t q[3], crd_t s[3], crd_t e[3]);
		@(negedge clk);
		req_valid <= 1;
		{query_x, query_y, query_z} <= {q[0], q[1], q[2]};
		{start_x, start_y, start_z} <= {s[0], s[1], s[2]};
		{end_x, end_y, end_z} <= {e[0], e[1], e[2]};
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_query(q, s, e);
	endtask

	task automatic idle(int n);
		@(negedge clk);
		req_valid <= 0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic crd_t rnd_crd(int sel);
		case (sel)
			0: return crd_t'($urandom);
			1: return crd_t'($urandom_range(0, 2000) - 1000);
			2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			default: return crd_t'($urandom_range(0, 1 << 20) - (1 << 19));
		endcase
	endfunction

	task automatic send_random();
		crd_t q[3], s[3], e[3];
		int sel;
		sel = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			q[i] = rnd_crd(sel);
			s[i] = rnd_crd(sel);
			e[i] = ($urandom_range(0, 15) == 0) ? s[i] : rnd_crd(sel);
			if ($urandom_range(0, 9) == 0)
				q[i] = rnd_crd($urandom_range(0, 3));
		end
		send_query(q, s, e);
	endtask

	initial begin
		crd_t mx, mn;
		int sent;
		mx = 24'h7fffff;
		mn = 24'h800000;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: degenerate, ties, extremes, each case
		send_query('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
		send_query('{5, 5, 5}, '{1, 2, 3}, '{1, 2, 3});
		send_query('{0, 7, 0}, '{0, 0, 0}, '{10, 0, 0});
		send_query('{10, 7, 0}, '{0, 0, 0}, '{10, 0, 0});
		send_query('{-3, 1, 0}, '{0, 0, 0}, '{10, 0, 0});
		send_query('{14, 1, 0}, '{0, 0, 0}, '{10, 0, 0});
		send_query('{5, 9, 2}, '{0, 0, 0}, '{10, 0, 0});
		send_query('{mx, mx, mx}, '{mn, mn, mn}, '{mn, mn, mn});
		send_query('{mn, mn, mn}, '{mx, mx, mx}, '{mx, mx, mx});
		send_query('{mx, mn, mx}, '{mn, mx, mn}, '{mx, mx, mx});
		send_query('{mx, mx, mx}, '{mn, mn, mn}, '{mx, mx, mx});
		send_query('{0, mx, 0}, '{mn, mn, mn}, '{mx, mx, mx});
		send_query('{mn, mx, mn}, '{mx, mn, mx}, '{mn, mn, mn});
		send_query('{0, 0, 0}, '{-1, -1, -1}, '{1, 1, 1});
		send_query('{24'h123456, 24'hfedcba, 24'h0f0f0f}, '{0, -65536, 65536},
			'{24'h3fffff, 24'h400000, -24'sd5});
		idle(1);
		// hold off until the pipeline drains
		while (sb.pending.size() != 0) @(posedge clk);
		sent = 0;
		while (sent < N_ITEMS) begin
			for (int k = $urandom_range(1, 40); k > 0 && sent < N_ITEMS; k--) begin
				send_random();
				sent++;
			end
			if ($urandom_range(0, 2) != 0)
				idle($urandom_range(1, 12));
		end
		idle(1);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("checked %0d results: start %0d, end %0d, interior %0d",
			sb.checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2]);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
